// File: rtl/glafe_pkg.sv
`default_nettype none
package glafe_pkg;

  localparam int unsigned MaxIndividualsDefault = 1024;
  localparam logic [24:0] OneQ24 = 25'd16777216;

  localparam logic [7:0]  MaxIterReset   = 8'd20;
  localparam logic [24:0] StartFreqReset = 25'd5033165;
  localparam logic [16:0] MissTolReset   = 17'd3277;
  localparam logic [24:0] ConvTolReset   = 25'd168;
  localparam logic [23:0] MinFreqReset   = 24'd838861;

  // register indexes
  localparam logic [2:0] RegMaxIter   = 3'd0;
  localparam logic [2:0] RegStartFreq = 3'd1;
  localparam logic [2:0] RegMissTol   = 3'd2;
  localparam logic [2:0] RegConvTol   = 3'd3;
  localparam logic [2:0] RegMinFreq   = 3'd4;

  // status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoKept  = 2'd1;
  localparam logic [1:0] StatusZeroDen = 2'd2;

  typedef struct packed {
    logic [15:0] lik_hom_major;
    logic [15:0] lik_het;
    logic [15:0] lik_hom_minor;
    logic        last_individual;
  } in_item_t;

  typedef struct packed {
    logic [24:0] allele_freq;
    logic [10:0] kept_count;
    logic        passes_filter;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_COEF, ST_READ, ST_WGT, ST_DIV, ST_ACC, ST_MEAN, ST_CHECK, ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // store item
    logic init;        // start estimate
    logic coef;        // compute pp pq qq
    logic clr_idx;     // restart walk, clear sum
    logic read;        // issue store read
    logic wgt;         // weights product
    logic div_start;
    logic acc;         // add posterior, advance
    logic mean_start;
    logic check;       // accept new estimate
    logic finish;      // emit result
    logic fail;        // zero denominator
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kept_zero;
    logic walk_end;
    logic entry_keep;
    logic den_zero;
    logic div_done;
    logic converged;
    logic iter_end;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/genotype_likelihood_allele_freq_em.sv
`default_nettype none
// Allele frequency EM over one site. Each individual is taken in one cycle
// (start while not busy); the last one starts the estimate and busy stays
// high until the result. The shared bit-serial divider serves the posterior
// of each kept individual in an EM pass and then the pass mean, and a site
// needs up to max_iterations such passes. The result is shown for a single
// cycle on result_valid, in the first cycle with busy low, and the receiver
// cannot hold it off.
module genotype_likelihood_allele_freq_em
  import glafe_pkg::*;
#(
  parameter int unsigned MaxIndividuals = MaxIndividualsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             result_valid,
  output out_item_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [7:0]  max_iterations;
  logic [24:0] start_freq, converge_tolerance;
  logic [16:0] missing_tolerance;
  logic [23:0] min_freq;
  cmd_t cmd;
  sts_t sts;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations     <= MaxIterReset;
      start_freq         <= StartFreqReset;
      missing_tolerance  <= MissTolReset;
      converge_tolerance <= ConvTolReset;
      min_freq           <= MinFreqReset;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegMaxIter:   max_iterations     <= pwdata[7:0];
        RegStartFreq: start_freq         <= pwdata[24:0];
        RegMissTol:   missing_tolerance  <= pwdata[16:0];
        RegConvTol:   converge_tolerance <= pwdata[24:0];
        RegMinFreq:   min_freq           <= pwdata[23:0];
        default:      ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      RegMaxIter:   prdata = 32'(max_iterations);
      RegStartFreq: prdata = 32'(start_freq);
      RegMissTol:   prdata = 32'(missing_tolerance);
      RegConvTol:   prdata = 32'(converge_tolerance);
      RegMinFreq:   prdata = 32'(min_freq);
      default:      prdata = '0;
    endcase
  end

  glafe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_in (in_item.last_individual),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  glafe_dp #(.MaxIndividuals(MaxIndividuals)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .item               (in_item),
    .max_iterations     (max_iterations),
    .start_freq         (start_freq),
    .missing_tolerance  (missing_tolerance),
    .converge_tolerance (converge_tolerance),
    .min_freq           (min_freq),
    .sts                (sts),
    .result_valid       (result_valid),
    .result             (result)
  );
endmodule
`default_nettype wire

// File: rtl/glafe_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module glafe_div
  import glafe_pkg::*;
#(
  parameter int unsigned NumW = 66,
  parameter int unsigned DenW = 42,
  parameter int unsigned QuoW = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [QuoW-1:0]      quo
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] nreg;
  logic [DenW-1:0] dreg;
  logic [DenW:0]   rem;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   shifted;
  logic            ge;

  assign shifted = {rem[DenW-1:0], nreg[NumW-1]};
  assign ge      = shifted >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= num;
      dreg <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      nreg <= {nreg[NumW-2:0], 1'b0};
      rem  <= ge ? shifted - {1'b0, dreg} : shifted;
      quo  <= {quo[QuoW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// File: rtl/glafe_ctrl.sv
`default_nettype none
// sequencer for load, em passes and result
module glafe_ctrl
  import glafe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic last_in,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start && last_in) state_next = ST_INIT;
      ST_INIT:  state_next = sts.kept_zero ? ST_DONE : ST_COEF;
      ST_COEF:  state_next = sts.iter_end ? ST_DONE : ST_READ;
      ST_READ:  state_next = sts.walk_end ? ST_MEAN : ST_WGT;
      ST_WGT:   begin
        if (!sts.entry_keep)    state_next = ST_READ;
        else if (sts.den_zero)  state_next = ST_DONE;
        else                    state_next = ST_DIV;
      end
      ST_DIV:   if (sts.div_done) state_next = ST_ACC;
      ST_ACC:   state_next = ST_READ;
      ST_MEAN:  if (sts.div_done) state_next = ST_CHECK;
      ST_CHECK: state_next = sts.converged ? ST_DONE : ST_COEF;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:  cmd.load = start;
      ST_INIT:  cmd.init = 1'b1;
      ST_COEF:  begin cmd.coef = 1'b1; cmd.clr_idx = 1'b1; end
      ST_READ:  begin
        cmd.read = 1'b1;
        cmd.mean_start = sts.walk_end;
      end
      ST_WGT:   begin
        cmd.wgt = 1'b1;
        cmd.fail = sts.entry_keep && sts.den_zero;
        cmd.div_start = sts.entry_keep && !sts.den_zero;
      end
      ST_DIV:   ;
      ST_ACC:   cmd.acc = 1'b1;
      ST_MEAN:  ;
      ST_CHECK: cmd.check = 1'b1;
      ST_DONE:  cmd.finish = 1'b1;
      default:  ;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == ST_IDLE) else $error("done not followed by idle");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_IDLE) else $error("load outside idle");
  a_fail_once: assert property (@(posedge clk) disable iff (rst)
    cmd.fail |=> state == ST_DONE) else $error("fail not ending");
endmodule
`default_nettype wire

// File: rtl/glafe_dp.sv
`default_nettype none
// likelihood store, em arithmetic and result register
module glafe_dp
  import glafe_pkg::*;
#(
  parameter int unsigned MaxIndividuals = MaxIndividualsDefault
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  input  wire in_item_t item,
  input  wire logic [7:0]  max_iterations,
  input  wire logic [24:0] start_freq,
  input  wire logic [16:0] missing_tolerance,
  input  wire logic [24:0] converge_tolerance,
  input  wire logic [23:0] min_freq,
  output sts_t       sts,
  output logic       result_valid,
  output out_item_t  result
);
  localparam int unsigned AddrW = (MaxIndividuals > 1) ? $clog2(MaxIndividuals) : 1;
  localparam int unsigned CntW  = $clog2(MaxIndividuals + 1);

  logic [48:0] store [MaxIndividuals];
  logic [CntW-1:0] ind_count, kept_ctr, idx;
  logic [24:0] cur_est, prev_est;
  logic [39:0] post_sum;
  logic [7:0]  pass_ctr;
  logic [24:0] pp, pq, qq;
  logic [48:0] rd;
  logic [41:0] w0, w1, w2;
  logic [43:0] dsum;
  logic        div_start, div_done;
  logic [65:0] div_num;
  logic [41:0] div_den;
  logic [24:0] div_quo;
  logic        is_mean;

  // keep decision
  logic [15:0] mx, mn;
  always_comb begin
    mx = item.lik_hom_major;
    mn = item.lik_hom_major;
    if (item.lik_het > mx) mx = item.lik_het;
    if (item.lik_hom_minor > mx) mx = item.lik_hom_minor;
    if (item.lik_het < mn) mn = item.lik_het;
    if (item.lik_hom_minor < mn) mn = item.lik_hom_minor;
  end
  logic keep_in;
  assign keep_in = {1'b0, mx - mn} >= missing_tolerance;

  // store write and read
  always_ff @(posedge clk) begin
    if (cmd.load && ind_count < CntW'(MaxIndividuals))
      store[ind_count[AddrW-1:0]] <= {keep_in, item.lik_hom_minor, item.lik_het,
                                      item.lik_hom_major};
    if (cmd.read) rd <= store[idx[AddrW-1:0]];
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ind_count <= '0;
      kept_ctr  <= '0;
    end else if (cmd.finish) begin
      ind_count <= '0;
      kept_ctr  <= '0;
    end else if (cmd.load && ind_count < CntW'(MaxIndividuals)) begin
      ind_count <= ind_count + 1'b1;
      kept_ctr  <= kept_ctr + CntW'(keep_in);
    end
  end

  // genotype coefficients from the previous estimate
  logic [24:0] qv;
  logic [49:0] m_pp, m_pq, m_qq;
  assign qv   = OneQ24 - prev_est;
  assign m_pp = prev_est * prev_est;
  assign m_pq = prev_est * qv;
  assign m_qq = qv * qv;

  // em state
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_ctr <= '0;
      cur_est  <= '0;
      prev_est <= '0;
      post_sum <= '0;
      idx      <= '0;
    end else begin
      if (cmd.init) begin
        cur_est  <= (start_freq > OneQ24) ? OneQ24 : start_freq;
        prev_est <= (start_freq > OneQ24) ? OneQ24 : start_freq;
        pass_ctr <= '0;
      end
      if (cmd.coef) begin
        pp <= m_pp[48:24];
        pq <= m_pq[48:24];
        qq <= m_qq[48:24];
      end
      if (cmd.clr_idx) begin
        idx      <= '0;
        post_sum <= '0;
      end else if (cmd.wgt && !rd[48]) begin
        idx <= idx + 1'b1;
      end else if (cmd.acc) begin
        idx      <= idx + 1'b1;
        post_sum <= post_sum + 40'(div_quo);
      end
      if (cmd.check) begin
        cur_est  <= div_quo;
        prev_est <= div_quo;
        pass_ctr <= pass_ctr + 1'b1;
      end
    end
  end

  // weights from the registered entry
  assign w0   = 42'(rd[15:0]) * 42'(qq);
  assign w1   = 42'({rd[31:16], 1'b0}) * 42'(pq);
  assign w2   = 42'(rd[47:32]) * 42'(pp);
  assign dsum = 44'(w0) + 44'(w1) + 44'(w2);

  // shared divider: posterior per entry, then mean over kept
  always_ff @(posedge clk) begin
    if (rst) begin
      is_mean <= 1'b0;
    end else if (cmd.div_start) begin
      is_mean <= 1'b0;
    end else if (cmd.mean_start) begin
      is_mean <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num <= {(44'(w1) + 44'(w2) + 44'(w2)), 22'd0} >> 0;
      div_den <= dsum[41:0];
    end else if (cmd.mean_start) begin
      div_num <= 66'(post_sum);
      div_den <= 42'(kept_ctr);
    end
  end
  // numerator for posterior: (w1+2w2)*2^24 / (2*dsum) = (w1+2w2)*2^23 / dsum
  logic [65:0] post_num;
  logic [41:0] post_den;
  assign post_num = is_mean ? div_num : (div_num >> 22) << 23;
  assign post_den = div_den;

  always_ff @(posedge clk) begin
    if (rst) div_start <= 1'b0;
    else     div_start <= cmd.div_start | cmd.mean_start;
  end

  glafe_div #(.NumW(66), .DenW(42), .QuoW(25)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (post_num),
    .den   (post_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // status back to controller
  logic [24:0] diff;
  assign diff = (div_quo > prev_est) ? div_quo - prev_est : prev_est - div_quo;

  always_comb begin
    sts.kept_zero  = (kept_ctr == '0);
    sts.walk_end   = (idx == ind_count);
    sts.entry_keep = rd[48];
    sts.den_zero   = (dsum == '0);
    sts.div_done   = div_done;
    sts.converged  = (diff < converge_tolerance) || (pass_ctr + 1'b1 >= max_iterations);
    sts.iter_end   = (pass_ctr >= max_iterations);
  end

  // result register
  logic        failed;
  logic [24:0] freq;
  logic [1:0]  stat;
  always_ff @(posedge clk) begin
    if (rst) failed <= 1'b0;
    else if (cmd.init) failed <= 1'b0;
    else if (cmd.fail) failed <= 1'b1;
  end

  always_comb begin
    if (kept_ctr == '0)  begin stat = StatusNoKept;  freq = '0; end
    else if (failed || cmd.fail) begin stat = StatusZeroDen; freq = '0; end
    else begin stat = StatusOk; freq = cur_est; end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= cmd.finish;
    if (cmd.finish) begin
      result.allele_freq   <= freq;
      result.kept_count    <= 11'(kept_ctr);
      result.status        <= stat;
      if (min_freq == '0)              result.passes_filter <= 1'b1;
      else if (stat == StatusZeroDen)  result.passes_filter <= 1'b0;
      else result.passes_filter <= (freq > {1'b0, min_freq}) &&
                                   (freq < OneQ24 - {1'b0, min_freq});
    end
  end

  a_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> idx < ind_count) else $error("walk past count");
  a_res: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid) else $error("result missing");
  a_kept: assert property (@(posedge clk) disable iff (rst)
    kept_ctr <= ind_count) else $error("kept above count");
endmodule
`default_nettype wire
